// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/ihcp_pkg.sv =====
// Package: constants, protocol numbers and result type of the IPv6 header chain parser.
`timescale 1ns / 1ps

package ihcp_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int END_BITS    = ((OFFSET_BITS > 11) ? OFFSET_BITS : 11) + 1;
    localparam int HLEN_BITS   = 12;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    localparam logic [7:0] PROTO_HOPOPT   = 8'd0;
    localparam logic [7:0] PROTO_IPV4     = 8'd4;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam logic [7:0] PROTO_ROUTING  = 8'd43;
    localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
    localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;
    localparam logic [7:0] PROTO_SCTP     = 8'd132;

    localparam logic [HLEN_BITS-1:0] FIXED_LEN = 12'd40;
    localparam logic [HLEN_BITS-1:0] FRAG_LEN  = 12'd8;
    localparam logic [HLEN_BITS-1:0] ROUTE_MIN = 12'd24;
    localparam logic [HLEN_BITS-1:0] ADDR_LEN  = 12'd16;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  next_protocol;
        logic [15:0] transport_offset;
        logic [15:0] payload_size;
        logic [7:0]  hop_limit;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [12:0] fragment_offset;
        logic        more_fragments;
        logic [31:0] fragment_ident;
    } res_t;

endpackage

// ===== rtl/core/ihcp_if.sv =====
// Stream interfaces: packet byte beats in, parse result beats out.
`timescale 1ns / 1ps

interface ihcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihcp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  next_protocol;
    logic [15:0] transport_offset;
    logic [15:0] payload_size;
    logic [7:0]  hop_limit;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [12:0] fragment_offset;
    logic        more_fragments;
    logic [31:0] fragment_ident;

    modport source (
        output valid, output status, output next_protocol, output transport_offset,
        output payload_size, output hop_limit, output source_high, output source_low,
        output dest_high, output dest_low, output fragment_offset,
        output more_fragments, output fragment_ident, input ready
    );
    modport sink (
        input valid, input status, input next_protocol, input transport_offset,
        input payload_size, input hop_limit, input source_high, input source_low,
        input dest_high, input dest_low, input fragment_offset,
        input more_fragments, input fragment_ident, output ready
    );
endinterface

// ===== rtl/core/ipv6_header_chain_parser_top.sv =====
// Top level: byte-serial IPv6 fixed header capture and extension header walk.
// The parser takes one packet byte per beat and sustains one beat per clock while
// packet.ready is high. All header decoding for a byte is done in combinational
// next-state logic on the parse registers, and the result for a packet is
// registered from the beat that carries last_byte. Results leave through an output
// register backed by one skid entry, so input beats keep flowing while a result
// waits; packet.ready drops only while both entries hold results. There is no
// clearing pass after reset.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ipv6_header_chain_parser_top (
    input logic       clk,
    input logic       rst_n,
    ihcp_in_if.sink   packet,
    ihcp_out_if.source result
);
    import ihcp_pkg::*;

    typedef enum logic [2:0] {
        KIND_FIXED,
        KIND_OPTS,
        KIND_ROUTE,
        KIND_FRAG,
        KIND_DONE
    } kind_t;

    typedef enum logic [2:0] {
        OUT_TRANSPORT  = 3'd0,
        OUT_FRAGMENTED = 3'd1,
        OUT_SHORT      = 3'd2,
        OUT_UNKNOWN    = 3'd3,
        OUT_PARSING    = 3'd4
    } outcome_t;

    function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [HLEN_BITS-1:0] n);
        logic [15:0] n_ext;
        n_ext = 16'(n);
        return (a > n_ext) ? (a - n_ext) : 16'd0;
    endfunction

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    kind_t                  kind_reg, kind_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [END_BITS-1:0]    end_reg, end_next;
    logic [7:0]             proto_reg, proto_next;
    logic [15:0]            remain_reg, remain_next;
    logic [7:0]             hops_reg, hops_next;
    logic [127:0]           src_reg, src_next;
    logic [127:0]           dst_reg, dst_next;
    logic                   segs_reg, segs_next;
    logic [12:0]            foff_reg, foff_next;
    logic                   fmf_reg, fmf_next;
    logic [31:0]            fid_reg, fid_next;
    outcome_t               outcome_reg, outcome_next;
    logic [7:0]             pnext_reg, pnext_next;
    logic [15:0]            poflg_reg, poflg_next;
    logic [31:0]            pid_reg, pid_next;
    logic [127:0]           pdst_reg, pdst_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    res_t                   out_reg, out_next;
    res_t                   skid_reg, skid_next;
    res_t                   res_new;

    logic                   accept;
    logic                   push;
    logic                   pop;
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] ofs;
    logic [OFFSET_BITS-1:0] count;
    logic [END_BITS-1:0]    diff;
    logic [END_BITS-1:0]    diff_done;
    logic [HLEN_BITS-1:0]   hlen;
    logic [HLEN_BITS-1:0]   hlen_done;
    logic                   frag_stop;
    logic                   do_dispatch;

    assign accept       = packet.valid && packet.ready;
    assign push         = accept && packet.last_byte;
    assign pop          = out_valid_reg && result.ready;
    assign packet.ready = !skid_valid_reg;
    assign b            = packet.data_byte;

    always_comb
    begin
        pos_next     = pos_reg;
        kind_next    = kind_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        proto_next   = proto_reg;
        remain_next  = remain_reg;
        hops_next    = hops_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        segs_next    = segs_reg;
        foff_next    = foff_reg;
        fmf_next     = fmf_reg;
        fid_next     = fid_reg;
        outcome_next = outcome_reg;
        pnext_next   = pnext_reg;
        poflg_next   = poflg_reg;
        pid_next     = pid_reg;
        pdst_next    = pdst_reg;
        frag_stop    = 1'b0;
        do_dispatch  = 1'b0;
        diff_done    = '0;
        hlen_done    = '0;

        ofs   = pos_reg - start_reg;
        count = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        diff  = end_reg - END_BITS'(start_reg);
        hlen  = diff[HLEN_BITS-1:0];

        pos_next = count;

        if (kind_reg != KIND_DONE)
        begin
            case (kind_reg)
                KIND_FIXED:
                begin
                    if (ofs == 4)
                        remain_next = {b, 8'h00};
                    else if (ofs == 5)
                        remain_next = remain_reg | 16'(b);
                    else if (ofs == 6)
                        proto_next = b;
                    else if (ofs == 7)
                        hops_next = b;
                    else if (ofs >= 8 && ofs < 24)
                        src_next = {src_reg[119:0], b};
                    else if (ofs >= 24 && ofs < 40)
                        dst_next = {dst_reg[119:0], b};
                end
                KIND_OPTS, KIND_ROUTE:
                begin
                    if (ofs == 0)
                        pnext_next = b;
                    else if (ofs == 1)
                        end_next = END_BITS'(start_reg)
                                 + END_BITS'({9'(b) + 9'd1, 3'b000});
                    else if (ofs == 3 && kind_reg == KIND_ROUTE)
                        segs_next = (b != 8'd0);
                    if (kind_reg == KIND_ROUTE && ofs >= 8 && segs_reg && hlen >= ROUTE_MIN
                        && 32'(ofs) >= 32'(hlen) - 32'(ADDR_LEN))
                        pdst_next = {pdst_reg[119:0], b};
                end
                KIND_FRAG:
                begin
                    if (ofs == 0)
                        pnext_next = b;
                    else if (ofs == 2)
                        poflg_next = {b, 8'h00};
                    else if (ofs == 3)
                        poflg_next = poflg_reg | 16'(b);
                    else if (ofs >= 4 && ofs < 8)
                        pid_next = {pid_reg[23:0], b};
                end
                default:
                begin
                end
            endcase

            if (END_BITS'(count) == end_next)
            begin
                diff_done  = end_next - END_BITS'(start_reg);
                hlen_done  = diff_done[HLEN_BITS-1:0];
                start_next = end_next[OFFSET_BITS-1:0];
                case (kind_reg)
                    KIND_OPTS, KIND_ROUTE:
                    begin
                        remain_next = sat_sub(remain_next, hlen_done);
                        proto_next  = pnext_next;
                        if (kind_reg == KIND_ROUTE && segs_next && hlen_done >= ROUTE_MIN)
                            dst_next = pdst_next;
                        do_dispatch = 1'b1;
                    end
                    KIND_FRAG:
                    begin
                        remain_next = sat_sub(remain_next, FRAG_LEN);
                        proto_next  = pnext_next;
                        foff_next   = poflg_next[15:3];
                        fmf_next    = poflg_next[0];
                        fid_next    = pid_next;
                        frag_stop   = (poflg_next[15:3] != 13'd0) || poflg_next[0];
                        if (frag_stop)
                        begin
                            kind_next    = KIND_DONE;
                            outcome_next = OUT_FRAGMENTED;
                        end
                        else
                            do_dispatch = 1'b1;
                    end
                    default:
                        do_dispatch = 1'b1;
                endcase

                if (do_dispatch)
                begin
                    end_next  = END_BITS'(start_next) + END_BITS'(FRAG_LEN);
                    segs_next = 1'b0;
                    pdst_next = '0;
                    if (proto_next inside {PROTO_HOPOPT, PROTO_DSTOPTS})
                        kind_next = KIND_OPTS;
                    else if (proto_next == PROTO_ROUTING)
                        kind_next = KIND_ROUTE;
                    else if (proto_next == PROTO_FRAGMENT)
                        kind_next = KIND_FRAG;
                    else if (proto_next inside {PROTO_TCP, PROTO_UDP, PROTO_SCTP, PROTO_IPV4})
                    begin
                        kind_next    = KIND_DONE;
                        outcome_next = OUT_TRANSPORT;
                    end
                    else
                    begin
                        kind_next    = KIND_DONE;
                        outcome_next = OUT_UNKNOWN;
                    end
                end
            end
        end

        res_new        = '0;
        res_new.status = (outcome_next == OUT_PARSING) ? 2'(OUT_SHORT) : 2'(outcome_next);
        if (kind_next != KIND_FIXED)
        begin
            res_new.next_protocol    = proto_next;
            res_new.transport_offset = 16'(32'(start_next));
            res_new.payload_size     = remain_next;
            res_new.hop_limit        = hops_next;
            res_new.source_high      = src_next[127:64];
            res_new.source_low       = src_next[63:0];
            res_new.dest_high        = dst_next[127:64];
            res_new.dest_low         = dst_next[63:0];
            res_new.fragment_offset  = foff_next;
            res_new.more_fragments   = fmf_next;
            res_new.fragment_ident   = fid_next;
        end

        if (packet.last_byte)
        begin
            pos_next     = '0;
            kind_next    = KIND_FIXED;
            start_next   = '0;
            end_next     = END_BITS'(FIXED_LEN);
            proto_next   = '0;
            remain_next  = '0;
            hops_next    = '0;
            src_next     = '0;
            dst_next     = '0;
            segs_next    = 1'b0;
            foff_next    = '0;
            fmf_next     = 1'b0;
            fid_next     = '0;
            outcome_next = OUT_PARSING;
            pnext_next   = '0;
            poflg_next   = '0;
            pid_next     = '0;
            pdst_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            kind_reg    <= KIND_FIXED;
            start_reg   <= '0;
            end_reg     <= END_BITS'(FIXED_LEN);
            proto_reg   <= '0;
            remain_reg  <= '0;
            hops_reg    <= '0;
            src_reg     <= '0;
            dst_reg     <= '0;
            segs_reg    <= 1'b0;
            foff_reg    <= '0;
            fmf_reg     <= 1'b0;
            fid_reg     <= '0;
            outcome_reg <= OUT_PARSING;
            pnext_reg   <= '0;
            poflg_reg   <= '0;
            pid_reg     <= '0;
            pdst_reg    <= '0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            kind_reg    <= kind_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            proto_reg   <= proto_next;
            remain_reg  <= remain_next;
            hops_reg    <= hops_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            segs_reg    <= segs_next;
            foff_reg    <= foff_next;
            fmf_reg     <= fmf_next;
            fid_reg     <= fid_next;
            outcome_reg <= outcome_next;
            pnext_reg   <= pnext_next;
            poflg_reg   <= poflg_next;
            pid_reg     <= pid_next;
            pdst_reg    <= pdst_next;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = res_new;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res_new;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = out_reg.status;
    assign result.next_protocol    = out_reg.next_protocol;
    assign result.transport_offset = out_reg.transport_offset;
    assign result.payload_size     = out_reg.payload_size;
    assign result.hop_limit        = out_reg.hop_limit;
    assign result.source_high      = out_reg.source_high;
    assign result.source_low       = out_reg.source_low;
    assign result.dest_high        = out_reg.dest_high;
    assign result.dest_low         = out_reg.dest_low;
    assign result.fragment_offset  = out_reg.fragment_offset;
    assign result.more_fragments   = out_reg.more_fragments;
    assign result.fragment_ident   = out_reg.fragment_ident;

    `ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_NEXT(a_push_to_empty_out, clk, rst_n, push && !out_valid_reg,
        out_valid_reg && !skid_valid_reg)
    `ASSERT_NEXT(a_stalled_result_held, clk, rst_n, out_valid_reg && !result.ready,
        out_valid_reg && $stable(out_reg))
    `ASSERT_IMPLY(a_walking_means_parsing, clk, rst_n, kind_reg != KIND_DONE,
        outcome_reg == OUT_PARSING)
    `ASSERT_IMPLY(a_done_has_outcome, clk, rst_n, kind_reg == KIND_DONE,
        outcome_reg != OUT_PARSING)

endmodule
